[rtl/pfb_pkg.sv]
// shared constants, codes and types for the palette framebuffer block
package pfb_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int FRAME_PIXELS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PALETTE_SIZE  = 256;

  localparam int ADDR_W  = $clog2(FRAME_PIXELS);
  localparam int OFF_W   = 20;
  localparam int SIZE_W  = 10;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 11;
  localparam int BASE_W  = OFF_W + 1;
  localparam int COUNT_W = 32;

  // reciprocal of the screen width for the offset split
  localparam int DIV_SHIFT = OFF_W + SIZE_W;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam longint DIV_RECIP = (64'd1 << DIV_SHIFT) / SCREEN_WIDTH;
  localparam int PROD_W    = OFF_W + RECIP_W;
  localparam int ROW_LIMIT = 2047;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int OUTQ_DEPTH  = 2;
  localparam int OPTR_W      = $clog2(OUTQ_DEPTH);

  // request command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_FILL  = 3'd2;
  localparam logic [2:0] CMD_PAL   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // classified operation kinds
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_PIXEL    = 3'd1;
  localparam logic [2:0] KIND_FILL     = 3'd2;
  localparam logic [2:0] KIND_PAL      = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_READ_OFF = 3'd5;
  localparam logic [2:0] KIND_NOP      = 3'd6;

  typedef struct packed {
    logic [2:0]        kind;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [7:0]        value;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } op_t;

  typedef struct packed {
    logic [7:0]         index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               off_screen;
    logic [COUNT_W-1:0] frame_count;
  } res_t;

endpackage

[rtl/pfb_front.sv]
// front end: takes requests and classifies them into operations
module pfb_front (
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 cmd,
  input  logic [pfb_pkg::OFF_W-1:0]  start_offset,
  input  logic [pfb_pkg::SIZE_W-1:0] rect_width,
  input  logic [pfb_pkg::SIZE_W-1:0] rect_height,
  input  logic [7:0]                 pixel_value,
  input  logic [7:0]                 red_in,
  input  logic [7:0]                 green_in,
  input  logic [7:0]                 blue_in,
  input  logic                       q_full,
  input  logic                       clearing,
  output logic                       op_push,
  output pfb_pkg::op_t               op
);
  import pfb_pkg::*;

  logic in_frame;

  assign full     = q_full | clearing;
  assign op_push  = push & ~full;
  assign in_frame = start_offset < OFF_W'(FRAME_PIXELS);

  always_comb begin
    unique case (cmd)
      CMD_START: op.kind = KIND_START;
      CMD_PIXEL: op.kind = KIND_PIXEL;
      CMD_FILL:  op.kind = KIND_FILL;
      CMD_PAL:   op.kind = KIND_PAL;
      CMD_READ:  op.kind = in_frame ? KIND_READ : KIND_READ_OFF;
      default:   op.kind = KIND_NOP;
    endcase
    op.offset = start_offset;
    op.w      = rect_width;
    op.h      = rect_height;
    op.value  = pixel_value;
    op.red    = red_in;
    op.green  = green_in;
    op.blue   = blue_in;
  end

endmodule

[rtl/pfb_queue.sv]
// short operation queue between front and back end
module pfb_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pfb_pkg::op_t din,
  output logic         full,
  input  logic         pop,
  output pfb_pkg::op_t dout,
  output logic         empty
);
  import pfb_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/pfb_back.sv]
// back end: offset split, region and fill writes, palette and pixel reads
module pfb_back (
  input  logic          clk,
  input  logic          rst,
  input  pfb_pkg::op_t  op,
  input  logic          op_valid,
  output logic          op_pop,
  output pfb_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full,
  output logic          clearing
);
  import pfb_pkg::*;

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DV_A     = 4'd2;
  localparam logic [3:0] ST_DV_B     = 4'd3;
  localparam logic [3:0] ST_DV_C     = 4'd4;
  localparam logic [3:0] ST_DV_D     = 4'd5;
  localparam logic [3:0] ST_FILL_CHK = 4'd6;
  localparam logic [3:0] ST_FILL_RUN = 4'd7;
  localparam logic [3:0] ST_PX       = 4'd8;
  localparam logic [3:0] ST_PAL      = 4'd9;
  localparam logic [3:0] ST_RD_A     = 4'd10;
  localparam logic [3:0] ST_RD_B     = 4'd11;
  localparam logic [3:0] ST_RD_C     = 4'd12;
  localparam logic [3:0] ST_EMIT     = 4'd13;

  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(DIV_RECIP);
  localparam logic [OFF_W-1:0]   SW_OFF   = OFF_W'(SCREEN_WIDTH);
  localparam logic [COL_W:0]     SW_X     = (COL_W+1)'(SCREEN_WIDTH);
  localparam logic [ROW_W:0]     SH_Y     = (ROW_W+1)'(SCREEN_HEIGHT);
  localparam logic [BASE_W-1:0]  SW_BASE  = BASE_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0]  SW_ADDR  = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0]  LAST_PIX = ADDR_W'(FRAME_PIXELS - 1);

  logic [3:0] state;
  logic [3:0] state_next;
  op_t        cur;

  // offset split
  logic [PROD_W-1:0] prod;
  logic [OFF_W-1:0]  q_est;
  logic [OFF_W-1:0]  qw;
  logic [COL_W-1:0]  div_col;
  logic [ROW_W-1:0]  div_row;
  logic [OFF_W-1:0]  rem;
  logic [OFF_W-1:0]  q_fix;

  // region state
  logic [COL_W-1:0]   origin_col;
  logic [ROW_W-1:0]   origin_row;
  logic [SIZE_W-1:0]  region_cols;
  logic [SIZE_W-1:0]  region_rows;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic [BASE_W-1:0]  row_base;
  logic [COUNT_W-1:0] frame_counter;

  // fill walker, also the clearing pass address
  logic [COL_W-1:0]  fill_x1;
  logic [ROW_W-1:0]  fill_y1;
  logic [COL_W-1:0]  fill_col;
  logic [ROW_W-1:0]  fill_row;
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_base;
  logic [COL_W:0]    x_end;
  logic [ROW_W:0]    y_end;
  logic              col_last;
  logic              row_last;

  // region pixel
  logic           px_active;
  logic [COL_W:0] px_x;
  logic [ROW_W:0] px_y;
  logic           px_on;
  logic [COL_W:0] col_inc;

  // memories
  logic [7:0]              frame_mem [FRAME_PIXELS];
  logic [23:0]             pal_mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] pal_valid;
  logic                    fb_we;
  logic [ADDR_W-1:0]       fb_waddr;
  logic [7:0]              fb_wdata;
  logic [7:0]              fb_rdata;
  logic [23:0]             pal_rdata;
  logic                    pal_hit;
  logic                    pal_we;

  // result fields other than the frame count
  logic [7:0] r_index;
  logic [7:0] r_red;
  logic [7:0] r_green;
  logic [7:0] r_blue;
  logic       r_off;

  assign clearing = state == ST_CLR;
  assign op_pop   = (state == ST_IDLE) && op_valid;
  assign res_push = (state == ST_EMIT) && !res_full;
  assign res      = '{index: r_index, red: r_red, green: r_green, blue: r_blue,
                      off_screen: r_off, frame_count: frame_counter};

  assign rem   = cur.offset - qw;
  assign q_fix = (rem >= SW_OFF) ? q_est + 1'b1 : q_est;

  assign x_end = {1'b0, div_col} + {1'b0, cur.w};
  assign y_end = {1'b0, div_row} + (ROW_W+1)'(cur.h);

  assign col_last = ({1'b0, fill_col} + 1'b1) == {1'b0, fill_x1};
  assign row_last = ({1'b0, fill_row} + 1'b1) == {1'b0, fill_y1};

  assign px_active = (region_cols != '0) && (cursor_row < ROW_W'(region_rows));
  assign px_x      = {1'b0, origin_col} + {1'b0, cursor_col};
  assign px_y      = {1'b0, origin_row} + {1'b0, cursor_row};
  assign px_on     = (px_x < SW_X) && (px_y < SH_Y);
  assign col_inc   = {1'b0, cursor_col} + 1'b1;

  assign pal_we = state == ST_PAL;

  always_comb begin
    fb_we    = 1'b0;
    fb_waddr = fill_addr;
    fb_wdata = cur.value;
    unique case (state)
      ST_CLR: begin
        fb_we    = 1'b1;
        fb_wdata = '0;
      end
      ST_FILL_RUN: begin
        fb_we = 1'b1;
      end
      ST_PX: begin
        fb_we    = px_active && px_on;
        fb_waddr = ADDR_W'(row_base + BASE_W'(px_x));
      end
      default: begin
        fb_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      frame_mem[fb_waddr] <= fb_wdata;
    end
    fb_rdata <= frame_mem[cur.offset[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[cur.value] <= {cur.red, cur.green, cur.blue};
    end
    pal_rdata <= pal_mem[fb_rdata];
    pal_hit   <= pal_valid[fb_rdata];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:      state_next = (fill_addr == LAST_PIX) ? ST_IDLE : ST_CLR;
      ST_IDLE: begin
        if (op_valid) begin
          unique case (op.kind)
            KIND_START, KIND_FILL: state_next = ST_DV_A;
            KIND_PIXEL:            state_next = ST_PX;
            KIND_PAL:              state_next = ST_PAL;
            KIND_READ:             state_next = ST_RD_A;
            default:               state_next = ST_EMIT;
          endcase
        end
      end
      ST_DV_A:     state_next = ST_DV_B;
      ST_DV_B:     state_next = ST_DV_C;
      ST_DV_C:     state_next = ST_DV_D;
      ST_DV_D:     state_next = (cur.kind == KIND_START) ? ST_EMIT : ST_FILL_CHK;
      ST_FILL_CHK: begin
        state_next = (div_col >= fill_x1 || div_row >= fill_y1) ? ST_EMIT : ST_FILL_RUN;
      end
      ST_FILL_RUN: state_next = (col_last && row_last) ? ST_EMIT : ST_FILL_RUN;
      ST_PX:       state_next = ST_EMIT;
      ST_PAL:      state_next = ST_EMIT;
      ST_RD_A:     state_next = ST_RD_B;
      ST_RD_B:     state_next = ST_RD_C;
      ST_RD_C:     state_next = ST_EMIT;
      ST_EMIT:     state_next = res_full ? ST_EMIT : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (op_pop) begin
      cur <= op;
    end
    prod    <= PROD_W'(cur.offset * RECIP);
    q_est   <= prod[DIV_SHIFT +: OFF_W];
    qw      <= OFF_W'(prod[DIV_SHIFT +: OFF_W] * SW_OFF);
    if (state == ST_DV_C) begin
      div_col <= COL_W'((rem >= SW_OFF) ? rem - SW_OFF : rem);
      div_row <= (q_fix > OFF_W'(ROW_LIMIT)) ? ROW_W'(ROW_LIMIT) : ROW_W'(q_fix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      fill_addr     <= '0;
      fill_base     <= '0;
      fill_col      <= '0;
      fill_row      <= '0;
      fill_x1       <= '0;
      fill_y1       <= '0;
      origin_col    <= '0;
      origin_row    <= '0;
      region_cols   <= '0;
      region_rows   <= '0;
      cursor_col    <= '0;
      cursor_row    <= '0;
      row_base      <= '0;
      frame_counter <= '0;
      pal_valid     <= '0;
      r_index       <= '0;
      r_red         <= '0;
      r_green       <= '0;
      r_blue        <= '0;
      r_off         <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLR: begin
          fill_addr <= fill_addr + 1'b1;
        end
        ST_IDLE: begin
          r_index <= '0;
          r_red   <= '0;
          r_green <= '0;
          r_blue  <= '0;
          r_off   <= op_valid && (op.kind == KIND_READ_OFF);
        end
        ST_DV_D: begin
          frame_counter <= frame_counter + 1'b1;
          if (cur.kind == KIND_START) begin
            origin_col  <= div_col;
            origin_row  <= div_row;
            region_cols <= cur.w;
            region_rows <= cur.h;
            cursor_col  <= '0;
            cursor_row  <= '0;
            row_base    <= BASE_W'(cur.offset) - BASE_W'(div_col);
          end else begin
            // clip the rectangle to the screen
            fill_x1   <= (x_end > SW_X) ? COL_W'(SCREEN_WIDTH) : x_end[COL_W-1:0];
            fill_y1   <= (y_end > SH_Y) ? ROW_W'(SCREEN_HEIGHT) : y_end[ROW_W-1:0];
            fill_col  <= div_col;
            fill_row  <= div_row;
            fill_addr <= cur.offset[ADDR_W-1:0];
            fill_base <= cur.offset[ADDR_W-1:0];
          end
        end
        ST_FILL_RUN: begin
          if (col_last) begin
            fill_col  <= div_col;
            fill_row  <= fill_row + 1'b1;
            fill_base <= fill_base + SW_ADDR;
            fill_addr <= fill_base + SW_ADDR;
          end else begin
            fill_col  <= fill_col + 1'b1;
            fill_addr <= fill_addr + 1'b1;
          end
        end
        ST_PX: begin
          if (px_active) begin
            r_off <= !px_on;
            if (col_inc >= {1'b0, region_cols}) begin
              cursor_col <= '0;
              cursor_row <= cursor_row + 1'b1;
              row_base   <= row_base + SW_BASE;
            end else begin
              cursor_col <= col_inc[COL_W-1:0];
            end
          end
        end
        ST_PAL: begin
          pal_valid[cur.value] <= 1'b1;
        end
        ST_RD_C: begin
          // palette entries never written read as the gray ramp
          r_index <= fb_rdata;
          r_red   <= pal_hit ? pal_rdata[23:16] : fb_rdata;
          r_green <= pal_hit ? pal_rdata[15:8] : fb_rdata;
          r_blue  <= pal_hit ? pal_rdata[7:0] : fb_rdata;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/pfb_outq.sv]
// two-entry result queue that parts the back end from the result side
module pfb_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfb_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output pfb_pkg::res_t dout,
  output logic          empty
);
  import pfb_pkg::*;

  res_t              slots [OUTQ_DEPTH];
  logic [OPTR_W-1:0] wr_ptr;
  logic [OPTR_W-1:0] rd_ptr;
  logic [OPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == (OPTR_W+1)'(OUTQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/palette_framebuffer_blit_fill.sv]
// top level of the indexed framebuffer with palette, region blit and fill
//
// channel   direction  handshake          payload
// request   in         push / full        cmd, start_offset, rect_width, rect_height,
//                                         pixel_value, red_in, green_in, blue_in
// result    out        empty / pop        pixel_index, red_out, green_out, blue_out,
//                                         off_screen, frame_count
//
// one request at a time in the back end, which has one frame store write port:
//   region pixel, palette write: one work state; read: frame store, then palette lookup
//   region start: three-step offset split by the screen width
//   fill: offset split, clip check, then one pixel per cycle of the clipped rectangle
// after reset the frame store is cleared one pixel a cycle, with full high
// up to four requests queue ahead of the back end, two results wait behind it
module palette_framebuffer_blit_fill (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd,
  input  logic [19:0] start_offset,
  input  logic [9:0]  rect_width,
  input  logic [9:0]  rect_height,
  input  logic [7:0]  pixel_value,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_index,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        off_screen,
  output logic [31:0] frame_count
);
  import pfb_pkg::*;

  // front end to queue
  op_t  front_op;
  logic front_push;
  logic q_full;

  // queue to back end
  op_t  q_op;
  logic q_empty;
  logic q_pop;

  // back end to result queue
  res_t back_res;
  logic back_push;
  logic outq_full;
  logic clearing;

  // head of the result queue
  res_t head;

  pfb_front u_front (
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .start_offset (start_offset),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .pixel_value  (pixel_value),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .q_full       (q_full),
    .clearing     (clearing),
    .op_push      (front_push),
    .op           (front_op)
  );

  // decouples request intake from the multi-cycle back end
  pfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_op),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_op),
    .empty (q_empty)
  );

  pfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (q_op),
    .op_valid (~q_empty),
    .op_pop   (q_pop),
    .res      (back_res),
    .res_push (back_push),
    .res_full (outq_full),
    .clearing (clearing)
  );

  // results wait here so a stalled consumer does not block the back end at once
  pfb_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .din   (back_res),
    .full  (outq_full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  assign pixel_index = head.index;
  assign red_out     = head.red;
  assign green_out   = head.green;
  assign blue_out    = head.blue;
  assign off_screen  = head.off_screen;
  assign frame_count = head.frame_count;

endmodule

[bench/pfb_checker.sv]
// result checker: shadow framebuffer and palette, predicts every request and compares in order
`timescale 1ns / 1ps
module pfb_checker
  import pfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  cmd,
  input  logic [19:0] start_offset,
  input  logic [9:0]  rect_width,
  input  logic [9:0]  rect_height,
  input  logic [7:0]  pixel_value,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  pixel_index,
  input  logic [7:0]  red_out,
  input  logic [7:0]  green_out,
  input  logic [7:0]  blue_out,
  input  logic        off_screen,
  input  logic [31:0] frame_count,
  output int          fail_count,
  output int          pending
);

  logic [7:0]         shadow_px [FRAME_PIXELS];
  logic [23:0]        shadow_lut [PALETTE_SIZE];
  int unsigned        org_col, org_row, reg_cols, reg_rows, cur_col, cur_row;
  logic [COUNT_W-1:0] frames;
  res_t               owed_results [$];
  bit                 model_ready = 1'b0;
  int                 errs = 0;

  assign fail_count = errs;

  task automatic clear_model();
    logic [7:0] shade;
    foreach (shadow_px[i]) shadow_px[i] = '0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      shade = 8'(i);
      shadow_lut[i] = {shade, shade, shade};
    end
    org_col  = 0;
    org_row  = 0;
    reg_cols = 0;
    reg_rows = 0;
    cur_col  = 0;
    cur_row  = 0;
    frames   = '0;
  endtask

  function automatic void split_offset(input logic [OFF_W-1:0] off,
                                       output int unsigned col, output int unsigned row);
    int unsigned quot;
    quot = off / SCREEN_WIDTH;
    col  = off % SCREEN_WIDTH;
    row  = (quot > ROW_LIMIT) ? ROW_LIMIT : quot;
  endfunction

  function automatic res_t apply_request(input logic [2:0] c, input logic [OFF_W-1:0] off,
                                         input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                         input logic [7:0] v, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
    res_t        res;
    int unsigned x0, y0, x1, y1, px, py;
    logic [7:0]  idx;
    res = '0;
    case (c)
      CMD_START: begin
        split_offset(off, org_col, org_row);
        reg_cols = 32'(w);
        reg_rows = 32'(h);
        cur_col  = 0;
        cur_row  = 0;
        frames++;
      end
      CMD_PIXEL: begin
        // nothing happens once the rectangle is used up or empty
        if (reg_cols != 0 && cur_row < reg_rows) begin
          px = org_col + cur_col;
          py = org_row + cur_row;
          if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) shadow_px[py * SCREEN_WIDTH + px] = v;
          else res.off_screen = 1'b1;
          cur_col++;
          if (cur_col >= reg_cols) begin
            cur_col = 0;
            cur_row++;
          end
        end
      end
      CMD_FILL: begin
        split_offset(off, x0, y0);
        x1 = x0 + 32'(w);
        y1 = y0 + 32'(h);
        if (x1 > SCREEN_WIDTH) x1 = SCREEN_WIDTH;
        if (y1 > SCREEN_HEIGHT) y1 = SCREEN_HEIGHT;
        for (int unsigned y = y0; y < y1; y++)
          for (int unsigned x = x0; x < x1; x++) shadow_px[y * SCREEN_WIDTH + x] = v;
        frames++;
      end
      CMD_PAL: begin
        shadow_lut[v] = {r, g, b};
      end
      CMD_READ: begin
        if (32'(off) < FRAME_PIXELS) begin
          idx       = shadow_px[off];
          res.index = idx;
          {res.red, res.green, res.blue} = shadow_lut[idx];
        end else begin
          res.off_screen = 1'b1;
        end
      end
      default: ;
    endcase
    res.frame_count = frames;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      if (!model_ready) clear_model();
      model_ready = 1'b1;
      owed_results.delete();
    end else begin
      if (push && !full)
        owed_results.push_back(apply_request(cmd, start_offset, rect_width, rect_height,
                                             pixel_value, red_in, green_in, blue_in));
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          errs++;
          $error("result popped with no request waiting for one");
        end else begin
          want = owed_results.pop_front();
          check_field("pixel_index", 32'(want.index), 32'(pixel_index));
          check_field("red_out", 32'(want.red), 32'(red_out));
          check_field("green_out", 32'(want.green), 32'(green_out));
          check_field("blue_out", 32'(want.blue), 32'(blue_out));
          check_field("off_screen", 32'(want.off_screen), 32'(off_screen));
          check_field("frame_count", want.frame_count, frame_count);
        end
      end
    end
    pending <= owed_results.size();
  end

endmodule

[bench/palette_framebuffer_blit_fill_tb.sv]
// testbench top: request stimulus, result pop pattern, watchdog and verdict
`timescale 1ns / 1ps
module palette_framebuffer_blit_fill_tb;
  import pfb_pkg::*;

  // commands the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1850;
  localparam int DRAIN_EVERY     = 400;
  // idle time after the last drain, before the verdict
  localparam int SETTLE_CYCLES   = 40;
  // watchdog limit; it covers the clear pass after reset and the rest of the run
  localparam int CYCLE_LIMIT     = 4_000_000;

  typedef enum int {POP_STREAM, POP_COIN, POP_TRICKLE} pop_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [2:0]  cmd = '0;
  logic [19:0] start_offset = '0;
  logic [9:0]  rect_width = '0;
  logic [9:0]  rect_height = '0;
  logic [7:0]  pixel_value = '0;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic        pop = 1'b0;
  logic        full, empty, off_screen;
  logic [7:0]  pixel_index, red_out, green_out, blue_out;
  logic [31:0] frame_count;

  int        fail_count, pending;
  int        cycles = 0;
  int        burst_left = 0;
  int        sent = 0;
  pop_mode_t pop_mode = POP_STREAM;
  int        pop_left = 0;

  palette_framebuffer_blit_fill u_top (
    .clk, .rst, .push, .full, .cmd, .start_offset, .rect_width, .rect_height,
    .pixel_value, .red_in, .green_in, .blue_in, .empty, .pop, .pixel_index,
    .red_out, .green_out, .blue_out, .off_screen, .frame_count
  );

  pfb_checker u_checker (
    .clk, .rst, .push, .full, .cmd, .start_offset, .rect_width, .rect_height,
    .pixel_value, .red_in, .green_in, .blue_in, .empty, .pop, .pixel_index,
    .red_out, .green_out, .blue_out, .off_screen, .frame_count, .fail_count, .pending
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: switches between full-rate popping, coin flips and rare pops
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_mode <= pop_mode_t'($urandom_range(0, 2));
        pop_left <= $urandom_range(20, 200);
      end else begin
        pop_left <= pop_left - 1;
      end
      case (pop_mode)
        POP_STREAM: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        default:    pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // one request, held until accepted; bursts and gaps are decided here
  task automatic send(input logic [2:0] c, input logic [19:0] off, input logic [9:0] w,
                      input logic [9:0] h, input logic [7:0] v, input logic [7:0] r,
                      input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    cmd          <= c;
    start_offset <= off;
    rect_width   <= w;
    rect_height  <= h;
    pixel_value  <= v;
    red_in       <= r;
    green_in     <= g;
    blue_in      <= b;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // stop sending until every owed result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // offsets mostly cluster in two corner windows and on the right edge so reads
  // land on pixels that regions and fills have touched; the rest are random, some past the frame
  function automatic logic [19:0] hot_offset();
    int unsigned row, col;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        row = $urandom_range(0, 5);
        col = $urandom_range(0, 11);
      end
      4, 5, 6: begin
        row = $urandom_range(SCREEN_HEIGHT - 6, SCREEN_HEIGHT - 1);
        col = $urandom_range(SCREEN_WIDTH - 12, SCREEN_WIDTH - 1);
      end
      7: begin
        row = $urandom_range(0, SCREEN_HEIGHT - 1);
        col = $urandom_range(SCREEN_WIDTH - 5, SCREEN_WIDTH - 1);
      end
      8: return 20'($urandom_range(0, (1 << OFF_W) - 1));
      default: return 20'($urandom_range(FRAME_PIXELS, (1 << OFF_W) - 1));
    endcase
    return 20'(row * SCREEN_WIDTH + col);
  endfunction

  // half the colors come from a few low entries so palette writes get read back
  function automatic logic [7:0] pick_color();
    return 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255));
  endfunction

  // region start followed by its pixels; an unfinished one stops partway
  task automatic region_burst(input bit complete);
    logic [19:0] org;
    logic [9:0]  w, h;
    int          n;
    org = hot_offset();
    if ($urandom_range(0, 7) == 0) begin
      w = 10'($urandom);
      h = 10'($urandom_range(0, 3));
    end else begin
      w = 10'($urandom_range(1, 6));
      h = 10'($urandom_range(1, 4));
    end
    n = int'(w) * int'(h);
    if (complete) n += $urandom_range(0, 2);   // a few excess pixels past the end
    else n = $urandom_range(0, n);
    if (n > 40) n = 40;
    send(CMD_START, org, w, h, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (n) send(CMD_PIXEL, 20'($urandom), 10'($urandom), 10'($urandom), pick_color(),
                    8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 1) == 0)
      send(CMD_READ, org, 10'($urandom), 10'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom));
  endtask

  task automatic fill_request();
    logic [9:0] w, h;
    if ($urandom_range(0, 19) == 0) begin
      w = 10'($urandom);
      h = 10'($urandom_range(0, 3));
    end else begin
      w = 10'($urandom_range(0, 8));
      h = 10'($urandom_range(0, 8));
    end
    send(CMD_FILL, hot_offset(), w, h, pick_color(), 8'($urandom), 8'($urandom),
         8'($urandom));
  endtask

  initial begin
    int pick;
    int next_drain;
    int goal;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset contents: zero framebuffer through the gray palette, and reads off the end
    send(CMD_READ, 20'd0, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send(CMD_READ, 20'(FRAME_PIXELS - 1), 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255);
    send(CMD_READ, 20'(FRAME_PIXELS), 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send(CMD_READ, 20'hFFFFF, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // palette extremes
    send(CMD_PAL, 20'd0, 10'd0, 10'd0, 8'd0, 8'd255, 8'd0, 8'd170);
    send(CMD_PAL, 20'd0, 10'd0, 10'd0, 8'd255, 8'd0, 8'd255, 8'd85);
    // pixel before any region is ignored
    send(CMD_PIXEL, 20'd0, 10'd0, 10'd0, 8'd9, 8'd0, 8'd0, 8'd0);
    // region straddling the right edge: clipped pixels, then one excess pixel
    send(CMD_START, 20'(SCREEN_WIDTH - 1), 10'd3, 10'd2, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (7) send(CMD_PIXEL, 20'd0, 10'd0, 10'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    send(CMD_READ, 20'(SCREEN_WIDTH - 1), 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send(CMD_READ, 20'(2 * SCREEN_WIDTH - 1), 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // fills: wide strip clipped, empty width, origin below the screen, last-pixel corner
    send(CMD_FILL, 20'd0, 10'd1023, 10'd4, 8'd255, 8'd0, 8'd0, 8'd0);
    send(CMD_FILL, 20'd0, 10'd0, 10'd5, 8'd7, 8'd0, 8'd0, 8'd0);
    send(CMD_FILL, 20'hFFFFF, 10'd1023, 10'd1023, 8'd3, 8'd0, 8'd0, 8'd0);
    send(CMD_FILL, 20'(FRAME_PIXELS - 1), 10'd1023, 10'd1023, 8'd0, 8'd0, 8'd0, 8'd0);
    // region entirely off screen, and one with zero width
    send(CMD_START, 20'hFFFFF, 10'd1023, 10'd1023, 8'd0, 8'd0, 8'd0, 8'd0);
    send(CMD_PIXEL, 20'd0, 10'd0, 10'd0, 8'd1, 8'd0, 8'd0, 8'd0);
    send(CMD_START, 20'd0, 10'd0, 10'd3, 8'd0, 8'd0, 8'd0, 8'd0);
    send(CMD_PIXEL, 20'd0, 10'd0, 10'd0, 8'd1, 8'd0, 8'd0, 8'd0);
    // unused command with every field set
    send(CMD_SPARE_HI, 20'hFFFFF, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255);
    send(CMD_READ, 20'd0, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send(CMD_READ, 20'(FRAME_PIXELS - 1), 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    wait_drained();

    goal       = sent + RANDOM_REQUESTS;
    next_drain = sent + DRAIN_EVERY;
    while (sent < goal) begin
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) region_burst(1'b1);
      else if (pick < 40) region_burst(1'b0);
      else if (pick < 62)
        send(CMD_READ, hot_offset(), 10'($urandom), 10'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 76) fill_request();
      else if (pick < 88)
        send(CMD_PAL, 20'($urandom), 10'($urandom), 10'($urandom), pick_color(),
             8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 95)
        // stray pixel, often past the end of the current region
        send(CMD_PIXEL, 20'($urandom), 10'($urandom), 10'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
      else
        send(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 20'($urandom), 10'($urandom),
             10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pfb_pkg.sv
rtl/pfb_front.sv
rtl/pfb_queue.sv
rtl/pfb_back.sv
rtl/pfb_outq.sv
rtl/palette_framebuffer_blit_fill.sv
bench/pfb_checker.sv
bench/palette_framebuffer_blit_fill_tb.sv
